[rtl/gtb_pkg.sv]
package gtb_pkg;

   localparam int TANH_TABLE_DEPTH = 256;
   localparam int TANH_IDX_W = $clog2(TANH_TABLE_DEPTH + 1);
   localparam int SPAN_Q16 = 262144;
   localparam int SPAN_SHIFT = 18;
   localparam int K_C1 = 52290;
   localparam int K_C2 = 2930;
   localparam int K_C2X3 = 8791;
   localparam int ONE_Q16 = 65536;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] OUT_MIN = -24'sh800000;

   typedef struct packed {
      logic signed [15:0] gate_value;
      logic signed [15:0] up_value;
      logic signed [15:0] grad_out;
      logic last_in;
   } req_type;

   typedef struct packed {
      logic signed [23:0] grad_gate;
      logic signed [23:0] grad_up;
      logic last_out;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] d;
      logic last;
      logic signed [31:0] a2;
   } front_item_type;

   typedef struct packed {
      logic full;
      logic almost_full;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

   typedef logic [16:0] tanh_rom_type [0:TANH_TABLE_DEPTH];

   function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] res;
      if (v > 64'(OUT_MAX)) begin
         res = OUT_MAX;
      end else if (v < 64'(OUT_MIN)) begin
         res = OUT_MIN;
      end else begin
         res = v[23:0];
      end
      return res;
   endfunction

   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] dv);
      logic [63:0] q;
      logic [63:0] rem;
      q = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n[i]};
         if (rem >= dv) begin
            rem = rem - dv;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
      logic [63:0] term;
      logic signed [63:0] sum;
      term = 64'd1073741824;
      sum = '0;
      for (int k = 0; k < 16; k++) begin
         if (k % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
         term = udiv((term * f) >> 16, 64'(k + 1));
      end
      return $unsigned(sum);
   endfunction

   function automatic logic [63:0] tanh_pos(input logic [63:0] x);
      logic [63:0] z;
      logic [63:0] n;
      logic [63:0] e1;
      logic [63:0] e;
      z = 2 * x;
      n = z >> 16;
      e1 = exp_neg_frac(64'd65536);
      e = exp_neg_frac(z & 64'hFFFF);
      for (int j = 0; j < 16; j++) begin
         if (64'(j) < n) begin
            e = (e * e1) >> 30;
         end
      end
      return udiv((64'd1073741824 - e) << 16, 64'd1073741824 + e);
   endfunction

   function automatic tanh_rom_type build_rom();
      tanh_rom_type rom;
      for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
         rom[i] = 17'(tanh_pos(udiv(64'(i) * 64'(SPAN_Q16), 64'(TANH_TABLE_DEPTH))));
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_rom();

endpackage

[rtl/gtb_front.sv]
module gtb_front
   import gtb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_item,
   input  queue_status_type q_status,
   output logic push,
   output front_item_type push_item
);

   logic valid_ff, valid_in;
   front_item_type item_ff, item_in;
   logic accept;

   assign busy = q_status.almost_full;
   assign accept = start && !busy;
   assign valid_in = accept;

   always_comb begin
      item_in.a = req_item.gate_value;
      item_in.b = req_item.up_value;
      item_in.d = req_item.grad_out;
      item_in.last = req_item.last_in;
      item_in.a2 = 32'(req_item.gate_value) * 32'(req_item.gate_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push = valid_ff;
   assign push_item = item_ff;

endmodule

[rtl/gtb_queue.sv]
module gtb_queue
   import gtb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  front_item_type push_item,
   output logic pop_valid,
   output front_item_type pop_item,
   output queue_status_type status
);

   front_item_type mem [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign pop_valid = (count_ff != '0);
   assign do_pop = pop_valid;
   assign do_push = push && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   assign status.full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.almost_full = (count_ff >= QUEUE_CNT_W'(QUEUE_DEPTH - 1));
   assign status.count = count_ff;

endmodule

[rtl/gtb_back.sv]
module gtb_back
   import gtb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  front_item_type in_item,
   output logic rsp_strobe,
   output rsp_type rsp_item
);

   localparam int NSTAGES = 12;

   typedef struct packed {
      logic last;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] d;
      logic signed [31:0] a2;
      logic signed [31:0] da;
      logic signed [31:0] db;
      logic signed [47:0] a3;
      logic signed [47:0] ca2;
      logic signed [31:0] inner;
      logic signed [31:0] gpin;
      logic signed [31:0] g;
      logic signed [31:0] gp;
      logic sat;
      logic neg;
      logic [16:0] lo;
      logic [17:0] diff;
      logic [17:0] r;
      logic signed [18:0] t;
      logic signed [39:0] tt;
      logic signed [63:0] up;
      logic signed [18:0] s2;
      logic signed [39:0] as2;
      logic signed [23:0] grad_up;
      logic signed [63:0] asg;
      logic signed [31:0] dg;
      logic signed [63:0] prod;
      logic signed [23:0] grad_gate;
   } bk_stage_type;

   bk_stage_type st_ff [1:NSTAGES];
   bk_stage_type st_in [1:NSTAGES];
   logic valid_ff [1:NSTAGES];
   logic valid_in [1:NSTAGES];

   always_comb begin
      logic signed [63:0] m;
      logic [63:0] p;
      logic [TANH_IDX_W-1:0] idx;
      logic [16:0] hi;
      logic [63:0] v;
      logic signed [63:0] s2w;

      for (int k = 2; k <= NSTAGES; k++) begin
         st_in[k] = st_ff[k-1];
         valid_in[k] = valid_ff[k-1];
      end
      st_in[1] = '0;
      valid_in[1] = in_valid;

      st_in[1].a = in_item.a;
      st_in[1].b = in_item.b;
      st_in[1].d = in_item.d;
      st_in[1].last = in_item.last;
      st_in[1].a2 = in_item.a2;
      st_in[1].da = 32'(in_item.d) * 32'(in_item.a);
      st_in[1].db = 32'(in_item.d) * 32'(in_item.b);

      st_in[2].a3 = 48'(st_ff[1].a2) * 48'(st_ff[1].a);
      st_in[2].ca2 = 48'(st_ff[1].a2) * 48'(K_C2X3);

      st_in[3].inner = 32'(rnd64((64'(st_ff[2].a) <<< 38) + 64'(K_C2) * 64'(st_ff[2].a3), 33));
      st_in[3].gpin = 32'(64'(ONE_Q16) + rnd64(64'(st_ff[2].ca2), 22));

      st_in[4].g = 32'(rnd64(64'(K_C1) * 64'(st_ff[3].inner), 16));
      st_in[4].gp = 32'(rnd64(64'(K_C1) * 64'(st_ff[3].gpin), 16));

      m = (st_ff[4].g < 0) ? -64'(st_ff[4].g) : 64'(st_ff[4].g);
      st_in[5].sat = (m >= 64'(SPAN_Q16));
      st_in[5].neg = (st_ff[4].g < 0);
      p = st_in[5].sat ? 64'd0 : $unsigned(m) * 64'(TANH_TABLE_DEPTH);
      idx = TANH_IDX_W'(p >> SPAN_SHIFT);
      hi = TANH_ROM[idx + 1'b1];
      st_in[5].lo = TANH_ROM[idx];
      st_in[5].diff = (hi > TANH_ROM[idx]) ? 18'(hi - TANH_ROM[idx]) : 18'd0;
      st_in[5].r = p[SPAN_SHIFT-1:0];

      v = st_ff[5].sat ? 64'(ONE_Q16)
         : 64'(st_ff[5].lo) + ((64'(st_ff[5].diff) * 64'(st_ff[5].r)) >> SPAN_SHIFT);
      st_in[6].t = st_ff[5].neg ? -19'(v) : 19'(v);

      st_in[7].tt = 40'(st_ff[6].t) * 40'(st_ff[6].t);
      st_in[7].up = 64'(st_ff[6].da) * (64'(ONE_Q16) + 64'(st_ff[6].t));

      s2w = 64'(ONE_Q16) - rnd64(64'(st_ff[7].tt), 16);
      st_in[8].s2 = 19'(s2w);
      st_in[8].as2 = 40'(st_ff[7].a) * 40'(s2w);
      st_in[8].grad_up = sat24(rnd64(st_ff[7].up, 28));

      st_in[9].asg = 64'(st_ff[8].as2) * 64'(st_ff[8].gp);

      st_in[10].dg = 32'(rnd64(((64'(ONE_Q16) + 64'(st_ff[9].t)) <<< 15)
                               + rnd64(st_ff[9].asg, 12), 16));

      st_in[11].prod = 64'(st_ff[10].db) * 64'(st_ff[10].dg);

      st_in[12].grad_gate = sat24(rnd64(st_ff[11].prod, 27));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NSTAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 1; k <= NSTAGES; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NSTAGES; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   assign rsp_strobe = valid_ff[NSTAGES];
   assign rsp_item.grad_gate = st_ff[NSTAGES].grad_gate;
   assign rsp_item.grad_up = st_ff[NSTAGES].grad_up;
   assign rsp_item.last_out = st_ff[NSTAGES].last;

endmodule

[rtl/geglu_tanh_backward.sv]
// GeGLU backward pass with the tanh form of GELU, one element per transaction.
// Input channel: a transaction is taken at a rising edge where start is high and
// busy is low; req_item carries the gate value, the up value, the upstream
// gradient and the last-element marker, all signed Q4.11 but the marker.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_item holding
// the gate gradient and the up gradient in saturated Q12.11 and the marker.
// The receiver cannot hold results off, and the block never needs it to.
// Between the accepting edge and the strobe lie the front register, the queue
// and the pipeline registers. Throughput is one transaction per cycle, set by
// the twelve-stage arithmetic pipeline behind a four-entry queue.
// Busy rises only if the queue nearly fills, which steady streaming never
// causes, so start may be held high on every cycle.
// Synchronous reset empties the queue and the pipeline; transactions in
// flight are dropped and no result appears until new ones are accepted.
// The tanh table is a constant ROM and needs no initialisation after reset.
module geglu_tanh_backward
   import gtb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_item,
   output logic rsp_strobe,
   output rsp_type rsp_item
);

   queue_status_type q_status;
   logic front_push;
   front_item_type front_item;
   logic q_valid;
   front_item_type q_item;

   gtb_front u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .q_status(q_status),
      .push(front_push),
      .push_item(front_item)
   );

   gtb_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(front_push),
      .push_item(front_item),
      .pop_valid(q_valid),
      .pop_item(q_item),
      .status(q_status)
   );

   gtb_back u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(q_valid),
      .in_item(q_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(front_push && q_status.full))
      else $error("Queue written while full.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("Queue count beyond its depth.");

   a_accept_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> front_push)
      else $error("Accepted transaction did not reach the queue.");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import gtb_pkg::*;

   localparam int NUM_RANDOM = 2000;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int TBL_DEPTH = 256;

   typedef struct {
      logic signed [15:0] gate;
      logic signed [15:0] up;
      logic signed [15:0] grad;
      logic last;
      bit known;
      logic signed [23:0] exp_gate;
      logic signed [23:0] exp_up;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;

   longint tanh_tbl [0:TBL_DEPTH];
   rsp_type pending_grads [$];
   int errors = 0;
   int cycles = 0;

   geglu_tanh_backward dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** geglu_tanh_backward: FAILED **");
         $finish;
      end
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint exp_neg_q30(longint unsigned f);
      longint unsigned term;
      longint sum;
      term = 64'd1073741824;
      sum = 0;
      for (int k = 0; k < 16; k++) begin
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
         term = (term * f) / (longint'(k + 1) << 16);
      end
      return sum;
   endfunction

   function automatic longint tanh_positive(longint unsigned x);
      longint unsigned z;
      longint unsigned e1;
      longint unsigned e;
      z = 2 * x;
      e1 = exp_neg_q30(64'd65536);
      e = exp_neg_q30(z & 64'hFFFF);
      for (longint unsigned j = 0; j < (z >> 16); j++) begin
         e = (e * e1) >> 30;
      end
      return ((64'd1073741824 - e) << 16) / (64'd1073741824 + e);
   endfunction

   function automatic longint tanh_interp(longint g);
      longint m;
      longint p;
      longint diff;
      longint v;
      m = (g < 0) ? -g : g;
      if (m >= 262144) begin
         v = 65536;
      end else begin
         p = m * TBL_DEPTH;
         diff = tanh_tbl[(p >> 18) + 1] - tanh_tbl[p >> 18];
         if (diff < 0) begin
            diff = 0;
         end
         v = tanh_tbl[p >> 18] + ((diff * (p & 64'h3FFFF)) >> 18);
      end
      return (g < 0) ? -v : v;
   endfunction

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > 8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -8388608) begin
         return -24'sh800000;
      end
      return v[23:0];
   endfunction

   function automatic rsp_type predict_grads(req_type r);
      longint a;
      longint b;
      longint d;
      longint inner;
      longint g;
      longint t;
      longint s2;
      longint gp;
      longint dg;
      rsp_type res;
      a = r.gate_value;
      b = r.up_value;
      d = r.grad_out;
      inner = round_shift(a * (64'sd1 <<< 38) + 2930 * (a * a * a), 33);
      g = round_shift(52290 * inner, 16);
      t = tanh_interp(g);
      s2 = 65536 - round_shift(t * t, 16);
      gp = round_shift(52290 * (65536 + round_shift(8791 * a * a, 22)), 16);
      dg = round_shift((65536 + t) * (64'sd1 <<< 15) + round_shift(a * s2 * gp, 12), 16);
      res.grad_gate = clamp24(round_shift(d * b * dg, 27));
      res.grad_up = clamp24(round_shift(d * a * (65536 + t), 28));
      res.last_out = r.last_in;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_grads.size() == 0) begin
            $error("unexpected result: grad_gate %0d grad_up %0d", rsp_item.grad_gate,
                   rsp_item.grad_up);
            errors = errors + 1;
         end else begin
            want = pending_grads.pop_front();
            if (rsp_item.grad_gate !== want.grad_gate) begin
               $error("grad_gate: expected %0d, actual %0d", want.grad_gate,
                      rsp_item.grad_gate);
               errors = errors + 1;
            end
            if (rsp_item.grad_up !== want.grad_up) begin
               $error("grad_up: expected %0d, actual %0d", want.grad_up, rsp_item.grad_up);
               errors = errors + 1;
            end
            if (rsp_item.last_out !== want.last_out) begin
               $error("last_out: expected %0b, actual %0b", want.last_out,
                      rsp_item.last_out);
               errors = errors + 1;
            end
         end
      end
   end

   task automatic send_element(req_type it, bit known, rsp_type typed_in);
      int gap;
      bit taken;
      rsp_type want;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) begin
         gap = 0;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      want = predict_grads(it);
      if (known && (want !== typed_in)) begin
         $error("grad_gate/grad_up: expected %0d/%0d, actual %0d/%0d", typed_in.grad_gate,
                typed_in.grad_up, want.grad_gate, want.grad_up);
         errors = errors + 1;
      end
      pending_grads.push_back(known ? typed_in : want);
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'(int'($urandom_range(0, 16383)) - 8192);
         2: return 16'(int'($urandom_range(0, 4095)) - 2048);
         3: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
         default: return 16'(int'($urandom_range(0, 24575)) - 12288);
      endcase
   endfunction

   dir_row_type dir_rows [] = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 24'sd0, 24'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 24'sd0, 24'sd0},
      '{16'sd0, 16'sd2048, 16'sd2048, 1'b0, 1'b1, 24'sd1024, 24'sd0},
      '{16'sd0, -16'sd2048, 16'sd2048, 1'b1, 1'b1, -24'sd1024, 24'sd0},
      '{16'sd2048, 16'sd0, 16'sd0, 1'b0, 1'b1, 24'sd0, 24'sd0},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b1, 1'b0, 24'sd0, 24'sd0},
      '{16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{-16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{16'sd2048, 16'sd2048, 16'sd2048, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{-16'sd2048, 16'sd2048, 16'sd2048, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{16'sd8192, 16'sd2048, 16'sd2048, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{-16'sd8192, 16'sd2048, 16'sd2048, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{16'sd4000, 16'sd2048, -16'sd2048, 1'b1, 1'b0, 24'sd0, 24'sd0},
      '{16'sd1, 16'sd1, 16'sd1, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{-16'sd1, 16'sd1, -16'sd1, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{16'sd3500, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{-16'sd3500, -16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{16'sd5555, 16'sd1234, 16'sd4321, 1'b1, 1'b0, 24'sd0, 24'sd0}
   };

   initial begin
      req_type it;
      rsp_type typed_in;
      int waited;
      for (int i = 0; i <= TBL_DEPTH; i++) begin
         tanh_tbl[i] = tanh_positive((longint'(i) * 262144) / TBL_DEPTH);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) begin
         it.gate_value = dir_rows[i].gate;
         it.up_value = dir_rows[i].up;
         it.grad_out = dir_rows[i].grad;
         it.last_in = dir_rows[i].last;
         typed_in.grad_gate = dir_rows[i].exp_gate;
         typed_in.grad_up = dir_rows[i].exp_up;
         typed_in.last_out = dir_rows[i].last;
         send_element(it, dir_rows[i].known, typed_in);
      end
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM / 2) begin
            start <= 1'b0;
            while (pending_grads.size() != 0) @(posedge clock);
         end
         it.gate_value = pick_value();
         it.up_value = pick_value();
         it.grad_out = pick_value();
         it.last_in = ($urandom_range(0, 7) == 0);
         send_element(it, 1'b0, typed_in);
      end
      start <= 1'b0;
      waited = 0;
      while (pending_grads.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_grads.size() == 0) begin
         $display("** geglu_tanh_backward: PASSED **");
      end else begin
         $display("** geglu_tanh_backward: FAILED **");
      end
      $finish;
   end

endmodule
